[sv/assert_macros.svh]
// Assertion macros used by the RTL core of the depth trial selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/dts_pkg.sv]
// Shared types and constants of the depth trial selector.
package dts_pkg;

  localparam int MAX_TRIALS = 64;
  localparam int IDX_W      = $clog2(MAX_TRIALS);
  localparam int CNT_W      = $clog2(MAX_TRIALS + 1);
  localparam int E_W        = 18;
  localparam int C_W        = 20;
  localparam int LIM_W      = 18;
  localparam int SUM_W      = E_W + 3;
  localparam int DIV_W      = E_W + 1;
  localparam int MUL_W      = C_W + 1;
  localparam int SQ_W       = 2 * C_W + 1;
  localparam int LSQ_W      = 2 * LIM_W;

  localparam logic signed [E_W-1:0] ONE_Q16 = E_W'(65536);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(768);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_END  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIM,
    S_LSQ,
    S_RD,
    S_ACC,
    S_CHK,
    S_DIV,
    S_DX,
    S_DY,
    S_CMP,
    S_NEXT,
    S_DEC,
    S_RRD,
    S_RACC,
    S_FRD,
    S_FLD
  } seq_state_t;

  typedef struct packed {
    logic signed [E_W-1:0] energy;
    logic signed [C_W-1:0] x;
    logic signed [C_W-1:0] y;
    logic signed [C_W-1:0] z;
    logic signed [C_W-1:0] radius;
  } trial_t;

  typedef struct packed {
    logic                  valid;
    logic signed [C_W-1:0] x;
    logic signed [C_W-1:0] y;
    logic signed [C_W-1:0] z;
    logic signed [C_W-1:0] radius;
    logic [IDX_W-1:0]      index;
    status_t               status;
  } result_t;

endpackage

[sv/depth_trial_selector_core.sv]
// Top level of the depth trial selector: input capture, trial store, output register.
// Usage: the depth trials of one marker arrive one per input transaction on
// in_valid / in_stall, the last one flagged by last_trial. start_x and start_y
// are sampled from the first trial of a marker only. Up to 64 trials are kept
// per marker and later ones are dropped, though their last_trial flag still
// closes the marker.
// After the last trial the block stalls its input and runs the selection on
// one divide unit and one shared multiplier under a sequencer. Each stored
// trial reads its window entries through the single memory read port; a
// three-to-five-wide window goes through the divide, a one-wide one skips it,
// and a two-wide one skips the distance check and compare as well. Refinement
// then scans two trials at least, and the fetch follows. Trials other than the
// last one are taken while the sequencer is idle and holds no pending result.
// One output transaction per marker appears on out_valid / out_stall; a result
// waiting under out_stall stays held in the output register, and the next
// marker's trials are taken meanwhile.
// max_xy_shift is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while idle, which the block itself does not enforce. Synchronous reset clears
// the trial count, the held start and the output valid, and sets max_xy_shift to 768.
module depth_trial_selector_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dts_pkg::LIM_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [dts_pkg::E_W-1:0] raw_energy,
  input  logic signed [dts_pkg::C_W-1:0] fit_x,
  input  logic signed [dts_pkg::C_W-1:0] fit_y,
  input  logic signed [dts_pkg::C_W-1:0] fit_z,
  input  logic signed [dts_pkg::C_W-1:0] fit_radius,
  input  logic signed [dts_pkg::C_W-1:0] start_x,
  input  logic signed [dts_pkg::C_W-1:0] start_y,
  input  logic                          last_trial,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [dts_pkg::C_W-1:0] chosen_x,
  output logic signed [dts_pkg::C_W-1:0] chosen_y,
  output logic signed [dts_pkg::C_W-1:0] chosen_z,
  output logic signed [dts_pkg::C_W-1:0] chosen_radius,
  output logic [dts_pkg::IDX_W-1:0]     chosen_index,
  output logic [1:0]                    status
);
  import dts_pkg::*;

  `include "assert_macros.svh"

  logic [LIM_W-1:0]      max_xy_shift;
  logic [CNT_W-1:0]      trial_count;
  logic signed [C_W-1:0] held_start_x;
  logic signed [C_W-1:0] held_start_y;

  logic             seq_ready;
  logic             in_take;
  logic             room;
  logic [CNT_W-1:0] count_next;
  logic             sel_start;
  logic [IDX_W-1:0] rd_addr;
  trial_t           rd_data;
  trial_t           wr_data;
  result_t          res;
  logic             res_take;
  logic             payload_zero;

  // Input transaction and the saturating trial count.
  always_comb begin
    in_stall   = !seq_ready;
    in_take    = in_valid && !in_stall;
    room       = trial_count < CNT_W'(MAX_TRIALS);
    count_next = room ? trial_count + CNT_W'(1) : trial_count;
    sel_start  = in_take && last_trial;
    wr_data.energy = raw_energy;
    wr_data.x      = fit_x;
    wr_data.y      = fit_y;
    wr_data.z      = fit_z;
    wr_data.radius = fit_radius;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_xy_shift <= LIM_RESET;
    end else if (cfg_wr_en) begin
      max_xy_shift <= cfg_wr_data;
    end
  end

  // Trial count and held marker start.
  always_ff @(posedge clk) begin
    if (rst) begin
      trial_count  <= '0;
      held_start_x <= '0;
      held_start_y <= '0;
    end else if (in_take) begin
      if (trial_count == '0) begin
        held_start_x <= start_x;
        held_start_y <= start_y;
      end
      trial_count <= last_trial ? '0 : count_next;
    end
  end

  dts_mem u_mem (
    .clk     (clk),
    .wr_en   (in_take && room),
    .wr_addr (trial_count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dts_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (sel_start),
    .start_n  (count_next),
    .lim      (max_xy_shift),
    .held_x   (held_start_x),
    .held_y   (held_start_y),
    .ready    (seq_ready),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res      (res),
    .res_take (res_take)
  );

  // Output register, loaded when empty or being drained.
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      chosen_x      <= res.x;
      chosen_y      <= res.y;
      chosen_z      <= res.z;
      chosen_radius <= res.radius;
      chosen_index  <= res.index;
      status        <= res.status;
    end
  end

  // Checks on the selection flow.
  assign payload_zero = (chosen_x == '0) && (chosen_y == '0) && (chosen_z == '0) &&
                        (chosen_radius == '0);

  `ASSERT_NEXT(a_take_loads_out, res_take, out_valid)
  `ASSERT_NEXT(a_count_cleared, sel_start, trial_count == '0)
  `ASSERT_SAME(a_busy_stalls_input, res.valid, in_stall)
  `ASSERT_SAME(a_fail_zero_payload, out_valid && status != ST_OK, payload_zero)

endmodule

[sv/dts_mem.sv]
// Trial store: one write port, one registered read port.
module dts_mem (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [dts_pkg::IDX_W-1:0] wr_addr,
  input  dts_pkg::trial_t         wr_data,
  input  logic [dts_pkg::IDX_W-1:0] rd_addr,
  output dts_pkg::trial_t         rd_data
);
  import dts_pkg::*;

  trial_t mem [MAX_TRIALS];

  // Write on store, read every cycle with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/dts_div.sv]
// Divide unit for the smoothing quotient: divides by one, two or three in one step.
module dts_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [dts_pkg::DIV_W-1:0] dividend,
  input  logic [1:0]              divisor,
  output logic                    busy,
  output logic [dts_pkg::DIV_W-1:0] quotient
);
  import dts_pkg::*;

  // Scaled reciprocal of three; the product is exact over the whole dividend range.
  localparam int RECIP_SH = DIV_W + 2;
  localparam int PROD_W   = 2 * DIV_W + 1;
  localparam logic [DIV_W:0] RECIP3 = (DIV_W+1)'((1 << RECIP_SH) / 3 + 1);

  logic [DIV_W-1:0]  dvd;
  logic [1:0]        dvs;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  q_next;

  // Quotient of the registered operands: pass, shift, or reciprocal multiply.
  always_comb begin
    prod = PROD_W'(dvd) * PROD_W'(RECIP3);
    unique case (dvs)
      2'd2:    q_next = dvd >> 1;
      2'd3:    q_next = {1'b0, prod[PROD_W-1:RECIP_SH]};
      default: q_next = dvd;
    endcase
  end

  // Busy for the one cycle in which the quotient is formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  // Operands are taken on start, the quotient in the following busy cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
    end
    if (busy) begin
      quotient <= q_next;
    end
  end

endmodule

[sv/dts_seq.sv]
// Selection sequencer: smoothing, distance mask, argmin, refinement, fetch.
module dts_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dts_pkg::CNT_W-1:0]   start_n,
  input  logic [dts_pkg::LIM_W-1:0]   lim,
  input  logic signed [dts_pkg::C_W-1:0] held_x,
  input  logic signed [dts_pkg::C_W-1:0] held_y,
  output logic                        ready,
  output logic [dts_pkg::IDX_W-1:0]   rd_addr,
  input  dts_pkg::trial_t             rd_data,
  output dts_pkg::result_t            res,
  input  logic                        res_take
);
  import dts_pkg::*;

  seq_state_t state, state_next;

  logic [CNT_W-1:0]        n;
  logic [CNT_W-1:0]        i;
  logic [CNT_W-1:0]        j;
  logic [IDX_W-1:0]        m;
  logic                    found;
  logic signed [E_W-1:0]   best;
  logic signed [SUM_W-1:0] sum;
  logic signed [E_W-1:0]   mn;
  logic signed [E_W-1:0]   mx;
  logic signed [E_W-1:0]   sm;
  logic                    neg;
  logic signed [C_W-1:0]   cur_x;
  logic signed [C_W-1:0]   cur_y;
  logic [LSQ_W-1:0]        limsq;
  logic signed [2*MUL_W-1:0] mul_q;
  logic [SQ_W-1:0]         dsq;
  logic                    res_valid;
  logic signed [C_W-1:0]   res_x, res_y, res_z, res_r;
  logic [IDX_W-1:0]        res_idx;
  status_t                 res_status;

  // Window bounds for the current trial, clipped to the stored range.
  logic [CNT_W:0]          ip2;
  logic [CNT_W-1:0]        last;
  logic [CNT_W-1:0]        win_lo;
  logic [CNT_W-1:0]        win_hi;
  logic [CNT_W-1:0]        win_cnt;

  always_comb begin
    last    = n - CNT_W'(1);
    ip2     = {1'b0, i} + (CNT_W+1)'(2);
    win_lo  = (i >= CNT_W'(2)) ? i - CNT_W'(2) : '0;
    win_hi  = (ip2 <= {1'b0, last}) ? ip2[CNT_W-1:0] : last;
    win_cnt = win_hi - win_lo + CNT_W'(1);
  end

  // Window numerator and its magnitude for the divider.
  logic signed [SUM_W-1:0] num;
  logic signed [SUM_W-1:0] mag;
  logic                    div_start;
  logic                    div_busy;
  logic [DIV_W-1:0]        div_q;
  logic signed [DIV_W:0]   q_s;

  always_comb begin
    num       = sum - SUM_W'(mn) - SUM_W'(mx);
    mag       = num[SUM_W-1] ? -num : num;
    div_start = (state == S_CHK) && (win_cnt >= CNT_W'(3));
    q_s       = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  end

  dts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag[DIV_W-1:0]),
    .divisor  (2'(win_cnt - CNT_W'(2))),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Shared multiplier: limit squared, then dx squared and dy squared per compared trial.
  logic signed [MUL_W-1:0] dx;
  logic signed [MUL_W-1:0] dy;
  logic signed [MUL_W-1:0] mul_a;

  always_comb begin
    dx = MUL_W'(cur_x) - MUL_W'(held_x);
    dy = MUL_W'(cur_y) - MUL_W'(held_y);
    unique case (state)
      S_LIM:   mul_a = $signed({{(MUL_W-LIM_W){1'b0}}, lim});
      S_DX:    mul_a = dx;
      default: mul_a = dy;
    endcase
  end

  // Distance mask and argmin update.
  logic [SQ_W:0] d2;
  logic          far;
  logic          take_min;

  always_comb begin
    d2       = {1'b0, dsq} + {1'b0, mul_q[SQ_W-1:0]};
    far      = d2 > (SQ_W+1)'(limsq);
    take_min = !far && (!found || (sm < best));
  end

  // Refinement step against raw energies.
  logic             ref_lt;
  logic [CNT_W-1:0] ref_m;
  logic [CNT_W-1:0] ref_j;
  logic [CNT_W:0]   ref_mp1;
  logic [CNT_W-1:0] ref_bnd;
  logic             ref_more;

  always_comb begin
    ref_lt   = rd_data.energy < best;
    ref_m    = ref_lt ? j : CNT_W'(m);
    ref_j    = j + CNT_W'(1);
    ref_mp1  = {1'b0, ref_m} + (CNT_W+1)'(1);
    ref_bnd  = (ref_mp1 <= {1'b0, last}) ? ref_mp1[CNT_W-1:0] : last;
    ref_more = ref_j <= ref_bnd;
  end

  // Decision on the argmin.
  logic dec_none;
  logic dec_end;

  always_comb begin
    dec_none = !found || (best == ONE_Q16);
    dec_end  = (m == '0) || (CNT_W'(m) == last);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and port outputs.
  always_comb begin
    state_next = state;
    ready      = (state == S_IDLE) && !res_valid;
    rd_addr    = (state == S_FRD) ? m : j[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LIM;
        end
      end
      S_LIM:  state_next = S_LSQ;
      S_LSQ:  state_next = S_RD;
      S_RD:   state_next = S_ACC;
      S_ACC: begin
        state_next = (j == win_hi) ? S_CHK : S_RD;
      end
      S_CHK: begin
        if (win_cnt == CNT_W'(2)) begin
          state_next = S_NEXT;
        end else if (win_cnt == CNT_W'(1)) begin
          state_next = S_DX;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_next = S_DX;
        end
      end
      S_DX:   state_next = S_DY;
      S_DY:   state_next = S_CMP;
      S_CMP:  state_next = S_NEXT;
      S_NEXT: begin
        state_next = (i == last) ? S_DEC : S_RD;
      end
      S_DEC: begin
        state_next = (dec_none || dec_end) ? S_IDLE : S_RRD;
      end
      S_RRD:  state_next = S_RACC;
      S_RACC: begin
        state_next = ref_more ? S_RRD : S_FRD;
      end
      S_FRD:  state_next = S_FLD;
      S_FLD:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Result handshake toward the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_DEC && (dec_none || dec_end)) || state == S_FLD) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  // Datapath registers, sequenced by state.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        n     <= start_n;
        i     <= '0;
        found <= 1'b0;
      end
      S_LIM: begin
        mul_q <= mul_a * mul_a;
      end
      S_LSQ: begin
        limsq <= mul_q[LSQ_W-1:0];
        j     <= '0;
      end
      S_ACC: begin
        if (j == win_lo) begin
          sum <= SUM_W'(rd_data.energy);
          mn  <= rd_data.energy;
          mx  <= rd_data.energy;
        end else begin
          sum <= sum + SUM_W'(rd_data.energy);
          if (rd_data.energy < mn) begin
            mn <= rd_data.energy;
          end
          if (rd_data.energy > mx) begin
            mx <= rd_data.energy;
          end
        end
        if (j == i) begin
          cur_x <= rd_data.x;
          cur_y <= rd_data.y;
        end
        j <= j + CNT_W'(1);
      end
      S_CHK: begin
        neg <= num[SUM_W-1];
        sm  <= sum[E_W-1:0];
      end
      S_DIV: begin
        sm <= q_s[E_W-1:0];
      end
      S_DX: begin
        mul_q <= mul_a * mul_a;
      end
      S_DY: begin
        dsq   <= mul_q[SQ_W-1:0];
        mul_q <= mul_a * mul_a;
      end
      S_CMP: begin
        if (take_min) begin
          found <= 1'b1;
          best  <= sm;
          m     <= i[IDX_W-1:0];
        end
      end
      S_NEXT: begin
        i <= i + CNT_W'(1);
        j <= (i >= CNT_W'(1)) ? i - CNT_W'(1) : '0;
      end
      S_DEC: begin
        res_x <= '0;
        res_y <= '0;
        res_z <= '0;
        res_r <= '0;
        if (dec_none) begin
          res_idx    <= '0;
          res_status <= ST_NONE;
        end else begin
          res_idx    <= m;
          res_status <= dec_end ? ST_END : ST_OK;
        end
        j <= CNT_W'(m) - CNT_W'(1);
      end
      S_RACC: begin
        if (ref_lt) begin
          best <= rd_data.energy;
          m    <= j[IDX_W-1:0];
        end
        j <= ref_j;
      end
      S_FLD: begin
        res_x   <= rd_data.x;
        res_y   <= rd_data.y;
        res_z   <= rd_data.z;
        res_r   <= rd_data.radius;
        res_idx <= m;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.valid  = res_valid;
    res.x      = res_x;
    res.y      = res_y;
    res.z      = res_z;
    res.radius = res_r;
    res.index  = res_idx;
    res.status = res_status;
  end

endmodule
